// ===== hw/rtl/dpq_pkg.sv =====
// dpq_pkg: shared constants for the dash pattern phase query block
// register index codes, field widths and parameter defaults
// no dependencies
package dpq_pkg;

  localparam int SEG_LEN_W    = 12;
  localparam int POS_W        = 16;
  localparam int COUNT_W      = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int NUM_LEN_REGS = 4;
  localparam int MIN_LEN_PX   = 2;
  localparam int REM_BITS_PER_STAGE = 4;

  localparam int DEF_MAX_SEGMENTS  = 4;
  localparam int DEF_SPAN_PIXELS   = 256;
  localparam int DEF_FRACTION_BITS = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_SEG_LEN_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG_LEN_3 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEG_COUNT = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE     = 3'd5;

endpackage

// ===== hw/rtl/dpq_if.sv =====
// dpq_if: valid/ready channels for query items and result items
// depends on dpq_pkg
interface dpq_query_if import dpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] query_position;

  modport source (output valid, output query_position, input ready);
  modport sink (input valid, input query_position, output ready);
endinterface

interface dpq_result_if;
  logic valid;
  logic ready;
  logic in_dash;
  logic length_fault;

  modport source (output valid, output in_dash, output length_fault, input ready);
  modport sink (input valid, input in_dash, input length_fault, output ready);
endinterface

// ===== hw/rtl/dash_pattern_phase_query.sv =====
// dash_pattern_phase_query: top level, dash pattern lookup for line positions
// depends on dpq_pkg and the channel interfaces in dpq_if
//
// use: write the segment lengths, the segment count and the phase offset
// through cfg_we / cfg_index / cfg_data while no query is in flight. each
// write starts a rebuild of the period, the repeated span and the phase
// shift; it runs through a bit-serial remainder unit (load, run and done
// states), during which query.ready is low. writes to unknown indexes
// change no register but still start a rebuild.
// query channel: one position per item; result channel: in_dash and
// length_fault, one result per query, in order.
// query pipeline: an input register, the pipelined remainder by the period
// (4 bits per stage) and an output register.
// throughput: one item per cycle once the rebuild is done and while the
// result receiver takes results; when it stalls, the whole pipeline
// holds and query.ready drops; nothing is lost or repeated.
// reset: synchronous, active high; zeroes config and valid bits (solid pen).
module dash_pattern_phase_query
  import dpq_pkg::*;
#(
  parameter int MAX_SEGMENTS  = DEF_MAX_SEGMENTS,
  parameter int SPAN_PIXELS   = DEF_SPAN_PIXELS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  dpq_query_if.sink              query,
  dpq_result_if.source           result
);

  localparam int PW    = SEG_LEN_W + $clog2(MAX_SEGMENTS);
  localparam int SPANQ = SPAN_PIXELS << FRACTION_BITS;
  localparam int SW    = $clog2(SPANQ + 1);
  localparam int TW    = (SW > PW) ? SW : PW;
  localparam int RW    = (SW > POS_W) ? SW : POS_W;
  localparam int CTW   = $clog2(RW + 1);
  localparam int DW    = ((PW > POS_W - 1) ? PW : POS_W - 1) + 1;
  localparam int BPS   = REM_BITS_PER_STAGE;
  localparam int NST   = (DW + BPS - 1) / BPS;
  localparam int DWP   = NST * BPS;
  localparam int CW    = ((TW > POS_W) ? TW : POS_W) + 1;
  localparam int NW    = $clog2(MAX_SEGMENTS + 1) + 1;
  localparam int MINQ  = MIN_LEN_PX << FRACTION_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // configuration registers
  logic [SEG_LEN_W-1:0]    seg_len [NUM_LEN_REGS];
  logic [COUNT_W-1:0]      seg_count;
  logic [POS_W-1:0]        phase_offset;

  // derived state
  logic [PW-1:0]           cum [MAX_SEGMENTS];
  logic [PW-1:0]           cum_next [MAX_SEGMENTS];
  logic [PW-1:0]           period;
  logic [TW-1:0]           total_span;
  logic [PW-1:0]           phase_shift;

  // rebuild sequencer
  logic [1:0]              st;
  logic [CTW-1:0]          cnt;
  logic [PW:0]             ra, rb, rc;
  logic [PW:0]             ra_next, rb_next, rc_next;
  logic [RW-1:0]           da, db, dc;
  logic                    busy;

  always_comb begin
    logic [NW-1:0]        n;
    logic [SEG_LEN_W-1:0] v;
    logic [PW-1:0]        acc;
    n = (NW'(seg_count) > NW'(MAX_SEGMENTS)) ? NW'(MAX_SEGMENTS) : NW'(seg_count);
    acc = '0;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      v = '0;
      if (k < NUM_LEN_REGS && NW'(k) < n) begin
        v = seg_len[k % NUM_LEN_REGS];
        if (v != '0 && v < SEG_LEN_W'(MINQ)) begin
          v = SEG_LEN_W'(MINQ);
        end
      end
      acc = acc + PW'(v);
      cum_next[k] = acc;
    end
  end

  assign period = cum[MAX_SEGMENTS-1];
  assign busy   = (st != S_IDLE);

  always_comb begin
    logic [PW:0] t;
    t = {ra[PW-1:0], da[RW-1]};
    ra_next = (t >= {1'b0, period}) ? t - {1'b0, period} : t;
    t = {rb[PW-1:0], db[RW-1]};
    rb_next = (t >= {1'b0, period}) ? t - {1'b0, period} : t;
    t = {rc[PW-1:0], dc[RW-1]};
    rc_next = (t >= {1'b0, period}) ? t - {1'b0, period} : t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_LEN_REGS; k++) begin
        seg_len[k] <= '0;
      end
      seg_count    <= '0;
      phase_offset <= '0;
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        cum[k] <= '0;
      end
      total_span  <= '0;
      phase_shift <= '0;
      st          <= S_IDLE;
      cnt         <= '0;
    end else begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        cum[k] <= cum_next[k];
      end
      if (cfg_we) begin
        if (cfg_index <= REG_SEG_LEN_3) begin
          seg_len[cfg_index[1:0]] <= cfg_data[SEG_LEN_W-1:0];
        end else if (cfg_index == REG_SEG_COUNT) begin
          seg_count <= cfg_data[COUNT_W-1:0];
        end else if (cfg_index == REG_PHASE) begin
          phase_offset <= cfg_data;
        end
        st <= S_LOAD;
      end else begin
        case (st)
          S_LOAD: begin
            st  <= S_RUN;
            cnt <= '0;
          end
          S_RUN: begin
            cnt <= cnt + 1'b1;
            if (cnt == CTW'(RW - 1)) begin
              st <= S_DONE;
            end
          end
          S_DONE: begin
            st <= S_IDLE;
            if (ra >= rb) begin
              phase_shift <= PW'(ra - rb);
            end else begin
              phase_shift <= PW'(ra + {1'b0, period} - rb);
            end
            if (period == '0) begin
              total_span <= '0;
            end else if (TW'(SPANQ) >= TW'(period)) begin
              total_span <= TW'(SPANQ) - TW'(rc);
            end else begin
              total_span <= TW'(period);
            end
          end
          default: st <= S_IDLE;
        endcase
      end
    end
  end

  // remainder datapath, no reset needed
  always_ff @(posedge clk) begin
    if (st == S_LOAD) begin
      ra <= '0;
      rb <= '0;
      rc <= '0;
      da <= RW'({~phase_offset[POS_W-1], phase_offset[POS_W-2:0]});
      db <= RW'(1) << (POS_W - 1);
      dc <= RW'(SPANQ);
    end else if (st == S_RUN) begin
      ra <= ra_next;
      rb <= rb_next;
      rc <= rc_next;
      da <= da << 1;
      db <= db << 1;
      dc <= dc << 1;
    end
  end

  // query pipeline
  logic            en;
  logic            take;
  logic            pv   [NST+1];
  logic            pok  [NST+1];
  logic            pflt [NST+1];
  logic [PW:0]     prem [NST+1];
  logic [DWP-1:0]  pdv  [NST+1];
  logic [PW:0]     srem [NST];
  logic [DWP-1:0]  sdv  [NST];
  logic            out_v;
  logic            out_dash;
  logic            out_fault;

  assign en          = !out_v || result.ready;
  assign query.ready = en && !busy;
  assign take        = query.valid && query.ready;

  always_comb begin
    logic [PW:0] t;
    for (int s = 0; s < NST; s++) begin
      srem[s] = prem[s];
      sdv[s]  = pdv[s];
      for (int b = 0; b < BPS; b++) begin
        t = {srem[s][PW-1:0], sdv[s][DWP-1]};
        srem[s] = (t >= {1'b0, period}) ? t - {1'b0, period} : t;
        sdv[s]  = sdv[s] << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic solid;
    logic in_rng;
    if (rst) begin
      for (int s = 0; s <= NST; s++) begin
        pv[s] <= 1'b0;
      end
      out_v <= 1'b0;
    end else if (en) begin
      pv[0] <= take;
      for (int s = 1; s <= NST; s++) begin
        pv[s] <= pv[s-1];
      end
      out_v <= pv[NST];
    end
    if (en) begin
      solid  = (seg_count == '0);
      in_rng = !query.query_position[POS_W-1] &&
               (CW'(query.query_position[POS_W-2:0]) < CW'(total_span));
      pflt[0] <= !solid && (period == '0);
      pok[0]  <= !solid && (period != '0) && in_rng;
      prem[0] <= '0;
      pdv[0]  <= DWP'(DW'(query.query_position[POS_W-2:0]) + DW'(phase_shift));
      for (int s = 1; s <= NST; s++) begin
        pflt[s] <= pflt[s-1];
        pok[s]  <= pok[s-1];
        prem[s] <= srem[s-1];
        pdv[s]  <= sdv[s-1];
      end
      out_fault <= pflt[NST];
      begin
        logic par;
        par = 1'b0;
        for (int k = 0; k < MAX_SEGMENTS; k++) begin
          par = par ^ (prem[NST][PW-1:0] >= cum[k]);
        end
        out_dash <= pok[NST] && !par;
      end
    end
  end

  assign result.valid        = out_v;
  assign result.in_dash      = out_dash;
  assign result.length_fault = out_fault;

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !query.ready)
    else $error("query taken during rebuild");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.in_dash && result.length_fault))
    else $error("dash and fault together");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.in_dash)))
    else $error("stalled result changed");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("write did not start rebuild");

endmodule
